### src/sha1_message_digest_macros.svh
// ---------------------------------------------------------------------------
// sha1_message_digest_macros.svh
// Assertion helpers for the port-level checker of the SHA-1 digest block.
// ---------------------------------------------------------------------------
`ifndef SHA1_MESSAGE_DIGEST_MACROS_SVH
`define SHA1_MESSAGE_DIGEST_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SHA1MD_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SHA1MD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/sha1md_pkg.sv
// ---------------------------------------------------------------------------
// sha1md_pkg
// Types and fixed constants of the SHA-1 digest block.
// ---------------------------------------------------------------------------
package sha1md_pkg;

    typedef logic [31:0] word_t;

    // Five working or chaining words, element 0 is a / H0.
    typedef logic [4:0][31:0] hash_t;

    typedef struct packed {
        logic       load;   // copy chaining words into the working words
        logic       step;   // run one round
        logic [6:0] rnd;    // round number of the current step
    } round_ctrl_t;

    localparam hash_t INIT_HASH = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                   32'hEFCDAB89, 32'h67452301};

    localparam word_t K0 = 32'h5A827999;
    localparam word_t K1 = 32'h6ED9EBA1;
    localparam word_t K2 = 32'h8F1BBCDC;
    localparam word_t K3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam word_t      PAD_WORD = {PAD_BYTE, 24'h000000};

    localparam int unsigned LEN_POS_BITS = 448;
    localparam logic [3:0]  LEN_HI_INDEX = 4'(LEN_POS_BITS / 32);
    localparam logic [3:0]  LEN_LO_INDEX = 4'(LEN_POS_BITS / 32 + 1);

    localparam logic [6:0] LAST_ROUND  = 7'd79;
    localparam logic [6:0] SCHED_START = 7'd16;

endpackage

### src/sha1md_buffer.sv
// ---------------------------------------------------------------------------
// sha1md_buffer
// 16-word block buffer: one write port, two registered read ports.
// ---------------------------------------------------------------------------
module sha1md_buffer (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [3:0]          wr_addr,
    input  sha1md_pkg::word_t   wr_data,
    input  logic [3:0]          rd_a_addr,
    input  logic [3:0]          rd_b_addr,
    output sha1md_pkg::word_t   rd_a_data,
    output sha1md_pkg::word_t   rd_b_data
);

    sha1md_pkg::word_t mem [16];
    sha1md_pkg::word_t rd_a_reg;
    sha1md_pkg::word_t rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem[rd_a_addr];
        rd_b_reg <= mem[rd_b_addr];
    end

    assign rd_a_data = rd_a_reg;
    assign rd_b_data = rd_b_reg;

endmodule

### src/sha1md_round.sv
// ---------------------------------------------------------------------------
// sha1md_round
// One SHA-1 round per step: message schedule from the buffer read ports,
// round function and the working words a..e.
// ---------------------------------------------------------------------------
module sha1md_round (
    input  logic                    clk,
    input  sha1md_pkg::round_ctrl_t ctrl,
    input  sha1md_pkg::hash_t       chain,
    input  sha1md_pkg::word_t       rd_a_data,
    input  sha1md_pkg::word_t       rd_b_data,
    output sha1md_pkg::word_t       sched_word,
    output sha1md_pkg::hash_t       work
);

    sha1md_pkg::hash_t work_reg;
    sha1md_pkg::word_t w_d1_reg;
    sha1md_pkg::word_t w_d2_reg;
    sha1md_pkg::word_t w_d3_reg;
    sha1md_pkg::word_t b_d1_reg;
    sha1md_pkg::word_t b_d2_reg;

    sha1md_pkg::word_t w_cur;
    sha1md_pkg::word_t w_mix;
    sha1md_pkg::word_t f_val;
    sha1md_pkg::word_t k_val;
    sha1md_pkg::word_t tmp;
    sha1md_pkg::word_t a_w;
    sha1md_pkg::word_t b_w;
    sha1md_pkg::word_t c_w;
    sha1md_pkg::word_t d_w;
    sha1md_pkg::word_t e_w;

    assign a_w = work_reg[0];
    assign b_w = work_reg[1];
    assign c_w = work_reg[2];
    assign d_w = work_reg[3];
    assign e_w = work_reg[4];

    // Port A holds w[t] in the first 16 rounds and w[t-8] after; port B
    // holds w[t-14], which two steps later is w[t-16].
    assign w_mix = w_d3_reg ^ rd_a_data ^ rd_b_data ^ b_d2_reg;
    assign w_cur = (ctrl.rnd < sha1md_pkg::SCHED_START)
                 ? rd_a_data : {w_mix[30:0], w_mix[31]};

    always_comb
    begin
        if (ctrl.rnd < 7'd20)
        begin
            f_val = (b_w & c_w) | (~b_w & d_w);
            k_val = sha1md_pkg::K0;
        end
        else if (ctrl.rnd < 7'd40)
        begin
            f_val = b_w ^ c_w ^ d_w;
            k_val = sha1md_pkg::K1;
        end
        else if (ctrl.rnd < 7'd60)
        begin
            f_val = (b_w & c_w) | (b_w & d_w) | (c_w & d_w);
            k_val = sha1md_pkg::K2;
        end
        else
        begin
            f_val = b_w ^ c_w ^ d_w;
            k_val = sha1md_pkg::K3;
        end
    end

    assign tmp = {a_w[26:0], a_w[31:27]} + f_val + e_w + k_val + w_cur;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            work_reg <= chain;
        end
        else if (ctrl.step)
        begin
            work_reg[0] <= tmp;
            work_reg[1] <= a_w;
            work_reg[2] <= {b_w[1:0], b_w[31:2]};
            work_reg[3] <= c_w;
            work_reg[4] <= d_w;
            w_d1_reg    <= w_cur;
            w_d2_reg    <= w_d1_reg;
            w_d3_reg    <= w_d2_reg;
            b_d1_reg    <= rd_b_data;
            b_d2_reg    <= b_d1_reg;
        end
    end

    assign sched_word = w_cur;
    assign work       = work_reg;

endmodule

### src/sha1_message_digest.sv
// ---------------------------------------------------------------------------
// sha1_message_digest
// SHA-1 digest of a byte message given as big-endian 32-bit words.
// ---------------------------------------------------------------------------
// Words are taken one per cycle, while data_ready is high, into a 16-word
// block buffer memory. The sixteenth word of a block starts a compression
// that holds data_ready low while it loads the working words, runs 80 rounds
// at one round per cycle (each round reads the buffer memory through its two
// read ports, and from round 16 on writes the new schedule word back) and
// folds the result into the chaining words. After the last word the block
// writes the pad, zero and length words one per cycle, pausing while it
// compresses (once or twice more), then presents the five digest
// words, H0 first, on consecutive handshakes; no word is taken meanwhile.
// An empty message is a last word with bytes_valid of zero.
module sha1_message_digest (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    output logic        data_ready,
    input  logic [31:0] data_word,
    input  logic [2:0]  bytes_valid,
    input  logic        last_word,
    output logic        digest_valid,
    input  logic        digest_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        digest_end
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_LOAD  = 3'd2;
    localparam logic [2:0] ST_ROUND = 3'd3;
    localparam logic [2:0] ST_FOLD  = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [2:0]        state_reg,    state_next;
    logic [3:0]        fill_reg,     fill_next;
    logic [63:0]       bit_len_reg,  bit_len_next;
    sha1md_pkg::hash_t chain_reg,    chain_next;
    logic [6:0]        rnd_reg,      rnd_next;
    logic              fin_reg,      fin_next;
    logic              pad_pend_reg, pad_pend_next;
    logic              hi_done_reg,  hi_done_next;
    logic              lo_done_reg,  lo_done_next;
    logic [2:0]        idx_reg,      idx_next;

    logic                    accept;
    logic [2:0]              nb_eff;
    sha1md_pkg::word_t       first_word;
    sha1md_pkg::word_t       pad_word;
    logic                    push_en;
    sha1md_pkg::word_t       push_data;
    logic                    sched_wr;
    logic                    wr_en;
    logic [3:0]              wr_addr;
    sha1md_pkg::word_t       wr_data;
    logic [6:0]              rnd_ahead;
    logic [3:0]              rd_a_addr;
    logic [3:0]              rd_b_addr;
    sha1md_pkg::word_t       rd_a_data;
    sha1md_pkg::word_t       rd_b_data;
    sha1md_pkg::word_t       sched_word;
    sha1md_pkg::hash_t       work;
    sha1md_pkg::round_ctrl_t rctrl;

    assign data_ready = (state_reg == ST_IDLE);
    assign accept     = data_valid && data_ready;

    // Clamp the byte count; only the last word may be partial.
    assign nb_eff = (!last_word || bytes_valid > 3'd4) ? 3'd4 : bytes_valid;

    always_comb
    begin
        case (nb_eff)
            3'd0:    first_word = sha1md_pkg::PAD_WORD;
            3'd1:    first_word = {data_word[31:24], sha1md_pkg::PAD_BYTE, 16'h0000};
            3'd2:    first_word = {data_word[31:16], sha1md_pkg::PAD_BYTE, 8'h00};
            3'd3:    first_word = {data_word[31:8], sha1md_pkg::PAD_BYTE};
            default: first_word = data_word;
        endcase
    end

    always_comb
    begin
        if (pad_pend_reg)
        begin
            pad_word = sha1md_pkg::PAD_WORD;
        end
        else if (fill_reg == sha1md_pkg::LEN_HI_INDEX)
        begin
            pad_word = bit_len_reg[63:32];
        end
        else if (fill_reg == sha1md_pkg::LEN_LO_INDEX && hi_done_reg)
        begin
            pad_word = bit_len_reg[31:0];
        end
        else
        begin
            pad_word = '0;
        end
    end

    assign push_en   = accept || (state_reg == ST_PAD);
    assign push_data = (state_reg == ST_PAD) ? pad_word : first_word;
    assign sched_wr  = (state_reg == ST_ROUND) && (rnd_reg >= sha1md_pkg::SCHED_START);

    assign wr_en   = push_en || sched_wr;
    assign wr_addr = sched_wr ? rnd_reg[3:0] : fill_reg;
    assign wr_data = sched_wr ? sched_word : push_data;

    // Issue the reads one round ahead of the round that uses them.
    assign rnd_ahead = (state_reg == ST_ROUND) ? rnd_reg + 7'd1 : 7'd0;
    assign rd_a_addr = (rnd_ahead < sha1md_pkg::SCHED_START)
                     ? rnd_ahead[3:0] : rnd_ahead[3:0] + 4'd8;
    assign rd_b_addr = rnd_ahead[3:0] + 4'd2;

    assign rctrl.load = (state_reg == ST_LOAD);
    assign rctrl.step = (state_reg == ST_ROUND);
    assign rctrl.rnd  = rnd_reg;

    sha1md_buffer u_buffer (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_a_addr (rd_a_addr),
        .rd_b_addr (rd_b_addr),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data)
    );

    sha1md_round u_round (
        .clk        (clk),
        .ctrl       (rctrl),
        .chain      (chain_reg),
        .rd_a_data  (rd_a_data),
        .rd_b_data  (rd_b_data),
        .sched_word (sched_word),
        .work       (work)
    );

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        bit_len_next  = bit_len_reg;
        chain_next    = chain_reg;
        rnd_next      = rnd_reg;
        fin_next      = fin_reg;
        pad_pend_next = pad_pend_reg;
        hi_done_next  = hi_done_reg;
        lo_done_next  = lo_done_reg;
        idx_next      = idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    bit_len_next  = bit_len_reg + {58'd0, nb_eff, 3'b000};
                    fill_next     = fill_reg + 4'd1;
                    pad_pend_next = last_word && (nb_eff == 3'd4);
                    fin_next      = last_word;
                    if (fill_reg == 4'hF)
                    begin
                        state_next = ST_LOAD;
                    end
                    else if (last_word)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                fill_next = fill_reg + 4'd1;
                if (pad_pend_reg)
                begin
                    pad_pend_next = 1'b0;
                end
                else if (fill_reg == sha1md_pkg::LEN_HI_INDEX)
                begin
                    hi_done_next = 1'b1;
                end
                else if (fill_reg == sha1md_pkg::LEN_LO_INDEX && hi_done_reg)
                begin
                    lo_done_next = 1'b1;
                end
                if (fill_reg == 4'hF)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                rnd_next   = '0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (rnd_reg == sha1md_pkg::LAST_ROUND)
                begin
                    state_next = ST_FOLD;
                end
                else
                begin
                    rnd_next = rnd_reg + 7'd1;
                end
            end
            ST_FOLD:
            begin
                for (int i = 0; i < 5; i++)
                begin
                    chain_next[i] = chain_reg[i] + work[i];
                end
                if (lo_done_reg)
                begin
                    idx_next   = '0;
                    state_next = ST_EMIT;
                end
                else if (fin_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (digest_ready)
                begin
                    if (idx_reg == 3'd4)
                    begin
                        // Back to the initial value for the next message.
                        chain_next   = sha1md_pkg::INIT_HASH;
                        bit_len_next = '0;
                        fill_next    = '0;
                        fin_next     = 1'b0;
                        hi_done_next = 1'b0;
                        lo_done_next = 1'b0;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            bit_len_reg  <= '0;
            chain_reg    <= sha1md_pkg::INIT_HASH;
            rnd_reg      <= '0;
            fin_reg      <= 1'b0;
            pad_pend_reg <= 1'b0;
            hi_done_reg  <= 1'b0;
            lo_done_reg  <= 1'b0;
            idx_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            bit_len_reg  <= bit_len_next;
            chain_reg    <= chain_next;
            rnd_reg      <= rnd_next;
            fin_reg      <= fin_next;
            pad_pend_reg <= pad_pend_next;
            hi_done_reg  <= hi_done_next;
            lo_done_reg  <= lo_done_next;
            idx_reg      <= idx_next;
        end
    end

    assign digest_valid = (state_reg == ST_EMIT);
    assign digest_word  = chain_reg[idx_reg];
    assign word_index   = idx_reg;
    assign digest_end   = (idx_reg == 3'd4);

endmodule

### src/sha1md_checker.sv
// ---------------------------------------------------------------------------
// sha1md_checker
// Port-level checks of the SHA-1 digest block, bound to the top level.
// ---------------------------------------------------------------------------
`include "sha1_message_digest_macros.svh"

module sha1md_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    input  logic        data_ready,
    input  logic [31:0] data_word,
    input  logic [2:0]  bytes_valid,
    input  logic        last_word,
    input  logic        digest_valid,
    input  logic        digest_ready,
    input  logic [31:0] digest_word,
    input  logic [2:0]  word_index,
    input  logic        digest_end
);

    // No word is taken while the digest is being handed out.
    `SHA1MD_ASSERT_IMPLY(a_no_input_on_emit, digest_valid, !data_ready, "word taken during digest")

    // A digest always starts at word zero.
    `SHA1MD_ASSERT_IMPLY(a_first_index, $rose(digest_valid), word_index == 3'd0, "digest starts off zero")

    // Digest words follow one another without a gap, in order.
    `SHA1MD_ASSERT_NEXT(a_burst, digest_valid && digest_ready && !digest_end, digest_valid && word_index == $past(word_index) + 3'd1, "digest words out of order")

    // Drop valid after the final digest word.
    `SHA1MD_ASSERT_NEXT(a_end_drop, digest_valid && digest_ready && digest_end, !digest_valid, "digest runs past its end")

    // A stalled digest word holds.
    `SHA1MD_ASSERT_NEXT(a_hold, digest_valid && !digest_ready, digest_valid && $stable(digest_word) && $stable(word_index), "stalled digest word changed")

endmodule

bind sha1_message_digest sha1md_checker u_checker (.*);

### dv/sha1_digest_checker.sv
// ---------------------------------------------------------------------------
// sha1_digest_checker
// Watches both channels of the SHA-1 digest block, keeps its own running
// SHA-1 state, predicts the five digest words of every message and compares
// each accepted digest word with the oldest prediction.
// ---------------------------------------------------------------------------
module sha1_digest_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    input  logic        data_ready,
    input  logic [31:0] data_word,
    input  logic [2:0]  bytes_valid,
    input  logic        last_word,
    input  logic        digest_valid,
    input  logic        digest_ready,
    input  logic [31:0] digest_word,
    input  logic [2:0]  word_index,
    input  logic        digest_end,
    output int          fail_count,
    output int          pending,
    output int          digests_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        sha1md_pkg::word_t value;
        logic [2:0]        index;
        logic              is_end;
    } digest_entry_t;

    digest_entry_t digest_q[$];

    sha1md_pkg::hash_t chain_h;
    sha1md_pkg::word_t sched_w [16];
    logic [63:0]       msg_bits;
    logic [3:0]        fill_ptr;

    function automatic sha1md_pkg::word_t rotl(input sha1md_pkg::word_t v,
                                               input int unsigned s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic void compress_block();
        sha1md_pkg::word_t a, b, c, d, e, f, k, w, t;
        int unsigned r;
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (r = 0; r < 80; r++)
        begin
            // expand the schedule in place over the 16-word window
            if (r < 16)
                w = sched_w[r];
            else
            begin
                w = rotl(sched_w[(r + 13) % 16] ^ sched_w[(r + 8) % 16] ^
                         sched_w[(r + 2) % 16] ^ sched_w[r % 16], 1);
                sched_w[r % 16] = w;
            end
            case (r / 20)
                0:       f = (b & c) | (~b & d);
                2:       f = (b & c) | (b & d) | (c & d);
                default: f = b ^ c ^ d;
            endcase
            case (r / 20)
                0:       k = sha1md_pkg::K0;
                1:       k = sha1md_pkg::K1;
                2:       k = sha1md_pkg::K2;
                default: k = sha1md_pkg::K3;
            endcase
            t = rotl(a, 5) + f + e + k + w;
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
        end
        chain_h[0] = chain_h[0] + a;
        chain_h[1] = chain_h[1] + b;
        chain_h[2] = chain_h[2] + c;
        chain_h[3] = chain_h[3] + d;
        chain_h[4] = chain_h[4] + e;
    endfunction

    function automatic void absorb_word(input sha1md_pkg::word_t w);
        sched_w[fill_ptr] = w;
        fill_ptr = fill_ptr + 4'd1;
        if (fill_ptr == 4'd0)
            compress_block();
    endfunction

    function automatic void predict_digest(input sha1md_pkg::word_t word,
                                           input logic [2:0] nbytes,
                                           input logic is_last);
        int unsigned nb;
        sha1md_pkg::word_t keep;
        int unsigned j;
        digest_entry_t ent;
        nb = nbytes;
        // only a final word may be short, and never beyond four bytes
        if (nb > 4 || !is_last)
            nb = 4;
        msg_bits = msg_bits + 64'(8 * nb);
        if (!is_last)
        begin
            absorb_word(word);
            return;
        end
        if (nb == 4)
        begin
            absorb_word(word);
            absorb_word(sha1md_pkg::PAD_WORD);
        end
        else
        begin
            keep = (nb == 0) ? '0 : (32'hFFFF_FFFF << (32 - 8 * nb));
            absorb_word((word & keep) | (sha1md_pkg::PAD_WORD >> (8 * nb)));
        end
        while (fill_ptr != sha1md_pkg::LEN_HI_INDEX)
            absorb_word('0);
        absorb_word(msg_bits[63:32]);
        absorb_word(msg_bits[31:0]);
        for (j = 0; j < 5; j++)
        begin
            ent.value  = chain_h[j];
            ent.index  = 3'(j);
            ent.is_end = (j == 4);
            digest_q.insert(digest_q.size(), ent);
        end
        chain_h = sha1md_pkg::INIT_HASH;
        msg_bits = '0;
        fill_ptr = '0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        digest_entry_t want;
        if (!rst_n)
        begin
            digest_q.delete();
            chain_h = sha1md_pkg::INIT_HASH;
            msg_bits = '0;
            fill_ptr = '0;
            fail_count = 0;
            pending = 0;
            digests_checked = 0;
        end
        else
        begin
            // compare outgoing word first, it never belongs to this cycle's input
            if (digest_valid && digest_ready)
            begin
                if (digest_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("[%0t] unexpected digest word %h index %0d end %b",
                                 $realtime, digest_word, word_index, digest_end);
                end
                else
                begin
                    want = digest_q.pop_front();
                    if (want.is_end)
                        digests_checked++;
                    if (digest_word !== want.value || word_index !== want.index ||
                        digest_end !== want.is_end)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("[%0t] digest mismatch: expected %h/%0d/%b got %h/%0d/%b",
                                     $realtime, want.value, want.index, want.is_end,
                                     digest_word, word_index, digest_end);
                    end
                end
            end
            if (data_valid && data_ready)
                predict_digest(data_word, bytes_valid, last_word);
            pending = digest_q.size();
        end
    end

endmodule

### dv/sha1_message_digest_tb.sv
// ---------------------------------------------------------------------------
// sha1_message_digest_tb
// Drives directed and random messages into the SHA-1 digest block with
// bursty input and varied output stalls; the checker predicts and compares
// every digest word, and this top gives the verdict.
// ---------------------------------------------------------------------------
module sha1_message_digest_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_GOAL   = 150;
    localparam int CYCLE_LIMIT = 400000;

    typedef enum int {
        READY_ALWAYS,
        READY_RANDOM,
        READY_PERIODIC,
        READY_SPARSE
    } stall_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        data_valid = 1'b0;
    logic        data_ready;
    logic [31:0] data_word = '0;
    logic [2:0]  bytes_valid = '0;
    logic        last_word = 1'b0;
    logic        digest_valid;
    logic        digest_ready = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_end;

    int fail_count;
    int pending;
    int digests_checked;
    int words_sent = 0;
    int messages_sent = 0;
    int burst_left = 0;
    int cycle_count = 0;

    always #2 clk = ~clk;

    sha1_message_digest uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_valid   (data_valid),
        .data_ready   (data_ready),
        .data_word    (data_word),
        .bytes_valid  (bytes_valid),
        .last_word    (last_word),
        .digest_valid (digest_valid),
        .digest_ready (digest_ready),
        .digest_word  (digest_word),
        .word_index   (word_index),
        .digest_end   (digest_end)
    );

    sha1_digest_checker digest_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .data_valid      (data_valid),
        .data_ready      (data_ready),
        .data_word       (data_word),
        .bytes_valid     (bytes_valid),
        .last_word       (last_word),
        .digest_valid    (digest_valid),
        .digest_ready    (digest_ready),
        .digest_word     (digest_word),
        .word_index      (word_index),
        .digest_end      (digest_end),
        .fail_count      (fail_count),
        .pending         (pending),
        .digests_checked (digests_checked)
    );

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(input logic [31:0] word, input logic [2:0] nbytes,
                             input logic is_last);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 3))
                0:       gap = 0;
                3:       gap = $urandom_range(12, 90);
                default: gap = $urandom_range(1, 6);
            endcase
        end
        burst_left--;
        if (gap > 0)
        begin
            data_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        data_valid  <= 1'b1;
        data_word   <= word;
        bytes_valid <= nbytes;
        last_word   <= is_last;
        do
            @(posedge clk);
        while (!data_ready);
        words_sent++;
        if (is_last)
            messages_sent++;
        @(negedge clk);
    endtask

    // Hold the input idle until every predicted digest word has come out.
    task automatic drain_results();
        data_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    initial
    begin : rx_pacing
        stall_mode_t mode;
        int span;
        int period;
        int phase;
        forever
        begin
            mode = stall_mode_t'($urandom_range(0, 3));
            span = $urandom_range(40, 400);
            period = $urandom_range(2, 9);
            for (phase = 0; phase < span; phase++)
            begin
                @(negedge clk);
                case (mode)
                    READY_ALWAYS:   digest_ready <= 1'b1;
                    READY_RANDOM:   digest_ready <= ($urandom_range(0, 1) == 1);
                    READY_PERIODIC: digest_ready <= ((phase % period) != 0);
                    default:        digest_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timed out after %0d cycles, %0d digest words still expected",
                 cycle_count, pending);
        $display("sha1_message_digest regression: fail");
        $finish;
    end

    initial
    begin : stimulus
        int n;
        int msg_len;
        int pick;
        int tail;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty message, then single-word messages with short and oversize tails
        send_word(32'h0000_0000, 3'd0, 1'b1);
        send_word(32'h6162_63FF, 3'd3, 1'b1);
        send_word(32'hFFFF_FFFF, 3'd1, 1'b1);
        send_word(32'hFFFF_FFFF, 3'd2, 1'b1);
        send_word(32'h0000_0000, 3'd4, 1'b1);
        send_word(32'hFFFF_FFFF, 3'd4, 1'b1);
        send_word(32'h1234_5678, 3'd7, 1'b1);
        // bytes_valid on a non-final word is ignored
        send_word(32'hFFFF_FFFF, 3'd0, 1'b0);
        send_word(32'hA5A5_A5A5, 3'd5, 1'b1);
        send_word(32'h0000_0000, 3'd6, 1'b0);
        send_word(32'hFFFF_FFFF, 3'd3, 1'b1);
        drain_results();

        // fourteen full words push the length field into a second block
        for (n = 0; n < 13; n++)
            send_word($urandom, 3'(n % 8), 1'b0);
        send_word($urandom, 3'd4, 1'b1);
        drain_results();

        while (words_sent < ITEM_GOAL)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 12)
                msg_len = $urandom_range(1, 8);
            else if (pick < 17)
                msg_len = $urandom_range(9, 20);
            else
                msg_len = $urandom_range(21, 40);
            for (n = 1; n < msg_len; n++)
                send_word($urandom, 3'($urandom_range(0, 7)), 1'b0);
            tail = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
            send_word($urandom, 3'(tail), 1'b1);
            if ($urandom_range(0, 7) == 0)
                drain_results();
        end
        data_valid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (300) @(posedge clk);

        $display("covered %0d messages in %0d words: empty, short and oversize tails,",
                 messages_sent, words_sent);
        $display("one- and two-block padding, %0d digests checked under varied stalls",
                 digests_checked);
        if (fail_count == 0)
            $display("sha1_message_digest regression: pass");
        else
            $display("sha1_message_digest regression: fail");
        $finish;
    end

endmodule
